// File: hw/rtl/rmst_pkg.sv
// ---------------------------------------------------------------------------
// rmst_pkg
// Shared types and codes for the range minimum segment tree.
// ---------------------------------------------------------------------------
package rmst_pkg;

  // Request mode codes as they arrive on the request port
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_LOWER = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Command kinds carried from front to back
  typedef enum logic [1:0] {
    OP_SET,
    OP_LOWER,
    OP_QUERY
  } op_t;

  // One classified command in the queue
  typedef struct packed {
    op_t         op;
    logic [9:0]  leaf_index;
    logic [31:0] leaf_value;  // already masked to the value width
    logic [10:0] lo;          // clamped; lo == hi marks an empty range
    logic [10:0] hi;          // clamped to the leaf count
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RUN,
    ST_QRY_RUN,
    ST_QRY_DONE
  } back_state_t;

endpackage

// File: hw/rtl/rmst_front.sv
// ---------------------------------------------------------------------------
// rmst_front
// Accepts request items, drops those with no effect, clamps query ranges
// and holds classified commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module rmst_front #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           mode,
  input  logic [9:0]           leaf_index,
  input  logic [31:0]          leaf_value,
  input  logic [10:0]          range_lo,
  input  logic [10:0]          range_hi,
  // back end side
  input  logic                 clearing,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output rmst_pkg::cmd_t       cmd
);

  localparam logic [31:0] LEAVES32   = 32'(LEAVES);
  localparam logic [31:0] VAL_MASK32 = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << VALUE_BITS) - 64'd1);

  rmst_pkg::cmd_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;

  rmst_pkg::cmd_t new_cmd;
  logic           keep;
  logic [31:0]    hi32;
  logic [31:0]    hi_c32;
  logic [10:0]    hi_c;
  logic           push;
  logic           pop;

  // Classify the incoming item
  always_comb begin
    hi32   = {21'b0, range_hi};
    hi_c32 = (hi32 > LEAVES32) ? LEAVES32 : hi32;
    hi_c   = hi_c32[10:0];

    new_cmd.leaf_index = leaf_index;
    new_cmd.leaf_value = leaf_value & VAL_MASK32;
    new_cmd.hi         = hi_c;
    new_cmd.lo         = (range_lo >= hi_c) ? hi_c : range_lo;
    new_cmd.op         = rmst_pkg::OP_QUERY;
    keep               = 1'b0;

    unique case (mode)
      rmst_pkg::MODE_SET: begin
        new_cmd.op = rmst_pkg::OP_SET;
        keep       = ({22'b0, leaf_index} < LEAVES32);
      end
      rmst_pkg::MODE_LOWER: begin
        new_cmd.op = rmst_pkg::OP_LOWER;
        keep       = ({22'b0, leaf_index} < LEAVES32);
      end
      rmst_pkg::MODE_QUERY: begin
        new_cmd.op = rmst_pkg::OP_QUERY;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Hold requests off while the tree is being cleared or the queue is full
  assign req_ready = !clearing && (count != 2'd2);
  assign push      = req_valid && req_ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= new_cmd;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/rmst_back.sv
// ---------------------------------------------------------------------------
// rmst_back
// Executes commands on the node memory: walks a leaf update up to the root,
// or walks a range query level by level, and holds the result item.
// ---------------------------------------------------------------------------
module rmst_back #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  rmst_pkg::cmd_t       cmd,
  output logic                 clearing,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [31:0]          range_min
);

  localparam int ADDR_W = $clog2(2 * LEAVES);
  localparam int R_W    = $clog2(2 * LEAVES + 1);
  localparam int DEPTH  = 2 * LEAVES;

  localparam logic [R_W-1:0]        LEAVES_R = R_W'(LEAVES);
  localparam logic [R_W-1:0]        ROOT     = R_W'(1);
  localparam logic [ADDR_W-1:0]     CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [VALUE_BITS-1:0] ONES     = '1;

  // Node memory: one write port, two registered read ports
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [VALUE_BITS-1:0] wd;
  logic [ADDR_W-1:0]     ra_a;
  logic [ADDR_W-1:0]     ra_b;
  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  // Sequencer registers
  rmst_pkg::back_state_t state, state_next;
  logic [ADDR_W-1:0]     clr_cnt, clr_cnt_next;
  logic [R_W-1:0]        node, node_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic [VALUE_BITS-1:0] cur, cur_next;
  logic                  first, first_next;
  logic                  lower, lower_next;
  logic [R_W-1:0]        l, l_next;
  logic [R_W-1:0]        r, r_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  pend, pend_next;
  logic                  use_l, use_l_next;
  logic                  use_r, use_r_next;
  logic                  rsp_valid_next;
  logic [31:0]           range_min_next;

  // Widened views of command fields
  logic [R_W+9:0]            idx_wide;
  logic [R_W+10:0]           lo_wide;
  logic [R_W+10:0]           hi_wide;
  logic [VALUE_BITS+63:0]    val_wide;
  logic [VALUE_BITS+31:0]    acc_wide;
  logic [R_W-1:0]            leaf_node;
  logic [R_W-1:0]            parent;
  logic [R_W-1:0]            r_dec;
  logic [VALUE_BITS-1:0]     cur_eff;
  logic [VALUE_BITS-1:0]     cand_a;
  logic [VALUE_BITS-1:0]     cand_b;
  logic [VALUE_BITS-1:0]     cand_m;

  assign idx_wide  = {{R_W{1'b0}}, cmd.leaf_index};
  assign lo_wide   = {{R_W{1'b0}}, cmd.lo};
  assign hi_wide   = {{R_W{1'b0}}, cmd.hi};
  assign val_wide  = {{VALUE_BITS{1'b0}}, 32'b0, cmd.leaf_value};
  assign acc_wide  = {32'b0, acc};
  assign leaf_node = LEAVES_R + idx_wide[R_W-1:0];
  assign parent    = node >> 1;
  assign r_dec     = r - R_W'(1);

  assign clearing  = (state == rmst_pkg::ST_CLEAR);
  assign cmd_ready = (state == rmst_pkg::ST_IDLE);

  // Value of the current node on this update step
  always_comb begin
    if (first) begin
      if (lower) begin
        cur_eff = (rd_a < val) ? rd_a : val;
      end else begin
        cur_eff = val;
      end
    end else begin
      cur_eff = cur;
    end
  end

  // Query candidates from the two read ports
  always_comb begin
    cand_a = use_l ? rd_a : ONES;
    cand_b = use_r ? rd_b : ONES;
    cand_m = (cand_a < cand_b) ? cand_a : cand_b;
  end

  // Next state and memory control
  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    node_next      = node;
    val_next       = val;
    cur_next       = cur;
    first_next     = first;
    lower_next     = lower;
    l_next         = l;
    r_next         = r;
    acc_next       = acc;
    pend_next      = pend;
    use_l_next     = use_l;
    use_r_next     = use_r;
    rsp_valid_next = rsp_valid;
    range_min_next = range_min;
    we             = 1'b0;
    wa             = clr_cnt;
    wd             = ONES;
    ra_a           = node[ADDR_W-1:0];
    ra_b           = node[ADDR_W-1:0];

    // Drop the held result once taken
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      rmst_pkg::ST_CLEAR: begin
        we           = 1'b1;
        wa           = clr_cnt;
        wd           = ONES;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == CLR_LAST) begin
          state_next = rmst_pkg::ST_IDLE;
        end
      end

      rmst_pkg::ST_IDLE: begin
        ra_a = leaf_node[ADDR_W-1:0];
        ra_b = (leaf_node ^ ROOT) >= R_W'(DEPTH) ? '0 : ADDR_W'(leaf_node ^ ROOT);
        if (cmd_valid) begin
          if (cmd.op == rmst_pkg::OP_QUERY) begin
            l_next     = LEAVES_R + lo_wide[R_W-1:0];
            r_next     = LEAVES_R + hi_wide[R_W-1:0];
            acc_next   = ONES;
            pend_next  = 1'b0;
            state_next = rmst_pkg::ST_QRY_RUN;
          end else begin
            node_next  = leaf_node;
            val_next   = val_wide[VALUE_BITS-1:0];
            lower_next = (cmd.op == rmst_pkg::OP_LOWER);
            first_next = 1'b1;
            state_next = rmst_pkg::ST_UPD_RUN;
          end
        end
      end

      // Write this node, fold in its sibling, move to the parent
      rmst_pkg::ST_UPD_RUN: begin
        we         = 1'b1;
        wa         = node[ADDR_W-1:0];
        wd         = cur_eff;
        ra_b       = ADDR_W'(parent ^ ROOT);
        first_next = 1'b0;
        if (node == ROOT) begin
          state_next = rmst_pkg::ST_IDLE;
        end else begin
          cur_next  = (cur_eff < rd_b) ? cur_eff : rd_b;
          node_next = parent;
        end
      end

      // Fold in last level's reads and issue this level's reads
      rmst_pkg::ST_QRY_RUN: begin
        ra_a = l[ADDR_W-1:0];
        ra_b = r_dec[ADDR_W-1:0];
        if (pend) begin
          acc_next = (acc < cand_m) ? acc : cand_m;
        end
        if (l < r) begin
          use_l_next = l[0];
          use_r_next = r[0];
          l_next     = (l + R_W'(l[0])) >> 1;
          r_next     = (r - R_W'(r[0])) >> 1;
          pend_next  = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = rmst_pkg::ST_QRY_DONE;
          end
        end
      end

      // Hand the result to the output register when it is free
      rmst_pkg::ST_QRY_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          range_min_next = acc_wide[31:0];
          state_next     = rmst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rmst_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      first     <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
      first     <= first_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    node      <= node_next;
    val       <= val_next;
    cur       <= cur_next;
    lower     <= lower_next;
    l         <= l_next;
    r         <= r_next;
    acc       <= acc_next;
    use_l     <= use_l_next;
    use_r     <= use_r_next;
    range_min <= range_min_next;
  end

endmodule

// File: hw/rtl/range_minimum_segment_tree.sv
// Update: the back end walks from the leaf up to the root, writing one node per tree level.
// Query: one node pair read per level, walking up the tree from both range ends.
// The back end takes one command at a time; a new one is accepted only after the last walk ends.
// A two-entry queue decouples acceptance from execution; results sit in an output register.
// Reset: a clearing pass writes all ones to every node of the node memory;
// no request is accepted until it completes.
// ---------------------------------------------------------------------------
// range_minimum_segment_tree
// Segment tree over LEAVES values with leaf set, leaf lower by minimum and
// half-open range minimum query.
// ---------------------------------------------------------------------------
module range_minimum_segment_tree #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  mode,
  input  logic [9:0]  leaf_index,
  input  logic [31:0] leaf_value,
  input  logic [10:0] range_lo,
  input  logic [10:0] range_hi,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] range_min
);

  logic           clearing;
  logic           cmd_valid;
  logic           cmd_ready;
  rmst_pkg::cmd_t cmd;

  // Accept and classify
  rmst_front #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .leaf_index (leaf_index),
    .leaf_value (leaf_value),
    .range_lo   (range_lo),
    .range_hi   (range_hi),
    .clearing   (clearing),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Execute on the node memory
  rmst_back #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .clearing   (clearing),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .range_min  (range_min)
  );

endmodule

// File: tb/tb_range_minimum_segment_tree.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_range_minimum_segment_tree
// Drives leaf set, leaf lower and range minimum query items into the segment
// tree. A short stimulus table covers reset contents, field extremes, the
// unused mode, clamped and empty ranges. A long random run follows, under
// several patterns of sender gaps and receiver stalls. Every query result is
// compared with a fixed table value or with a behavioural copy of the tree.
// ---------------------------------------------------------------------------
module tb_range_minimum_segment_tree;

  localparam int          LEAVES       = 1024;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [1:0]  MODE_SET     = rmst_pkg::MODE_SET;
  localparam logic [1:0]  MODE_LOWER   = rmst_pkg::MODE_LOWER;
  localparam logic [1:0]  MODE_QUERY   = rmst_pkg::MODE_QUERY;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 1870;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 40;

  // One row of the stimulus table; want is used only when fixed is set
  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  idx;
    logic [31:0] val;
    logic [10:0] lo;
    logic [10:0] hi;
    bit          fixed;
    logic [31:0] want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  mode;
  logic [9:0]  leaf_index;
  logic [31:0] leaf_value;
  logic [10:0] range_lo;
  logic [10:0] range_hi;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] range_min;

  // Behavioural tree: node 1 is the root, leaf k sits at node LEAVES+k
  logic [31:0] min_tree [1:2*LEAVES-1];
  logic [31:0] pending_min_q [$];
  stim_row_t   stim_table [$];
  logic [31:0] oldest_min;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          rsp_stall_pct  = 0;

  range_minimum_segment_tree u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .leaf_index (leaf_index),
    .leaf_value (leaf_value),
    .range_lo   (range_lo),
    .range_hi   (range_hi),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .range_min  (range_min)
  );

  always #5 clk = ~clk;

  // Apply one item to the tree copy; report the minimum for a query
  function automatic void tree_apply(input logic [1:0] op, input logic [9:0] idx,
                                     input logic [31:0] val, input logic [10:0] lo,
                                     input logic [10:0] hi, output bit has_min,
                                     output logic [31:0] min_val);
    int node;
    int l;
    int r;
    int top;
    has_min = 1'b0;
    min_val = ALL_ONES;
    case (op)
      MODE_SET, MODE_LOWER: begin
        node = LEAVES + int'(idx);
        if (op == MODE_SET) begin
          min_tree[node] = val;
        end else if (val < min_tree[node]) begin
          min_tree[node] = val;
        end
        // recompute every ancestor up to the root
        for (node = node >> 1; node >= 1; node = node >> 1) begin
          min_tree[node] = (min_tree[2*node] < min_tree[2*node+1]) ?
                           min_tree[2*node] : min_tree[2*node+1];
        end
      end
      MODE_QUERY: begin
        has_min = 1'b1;
        top = (int'(hi) > LEAVES) ? LEAVES : int'(hi);
        l = LEAVES + int'(lo);
        r = LEAVES + top;
        // bottom-up walk; an empty range leaves the identity
        while (int'(lo) < top && l < r) begin
          if (l[0]) begin
            if (min_tree[l] < min_val) min_val = min_tree[l];
            l++;
          end
          if (r[0]) begin
            r--;
            if (min_tree[r] < min_val) min_val = min_tree[r];
          end
          l = l >> 1;
          r = r >> 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [9:0] idx,
                                  input logic [31:0] val, input logic [10:0] lo,
                                  input logic [10:0] hi, input bit fixed,
                                  input logic [31:0] want);
    stim_row_t row;
    row.op    = op;
    row.idx   = idx;
    row.val   = val;
    row.lo    = lo;
    row.hi    = hi;
    row.fixed = fixed;
    row.want  = want;
    stim_table.push_back(row);
  endfunction

  // Present one item, hold it until accepted, then record what it should give
  task automatic issue_request(input logic [1:0] op, input logic [9:0] idx,
                               input logic [31:0] val, input logic [10:0] lo,
                               input logic [10:0] hi, input bit fixed,
                               input logic [31:0] want);
    bit          has_min;
    logic [31:0] pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= op;
    leaf_index <= idx;
    leaf_value <= val;
    range_lo   <= lo;
    range_hi   <= hi;
    do @(posedge clk); while (!req_ready);
    tree_apply(op, idx, val, lo, hi, has_min, pred);
    if (has_min) pending_min_q.push_back(fixed ? want : pred);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_min_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, range_min);
        mismatch_count++;
      end else begin
        oldest_min = pending_min_q.pop_front();
        if (range_min !== oldest_min) begin
          $display("%0t: range_min mismatch: expected %h, got %h",
                   $time, oldest_min, range_min);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          k;
    int          pick;
    int          a;
    int          b;
    logic [1:0]  op;
    logic [9:0]  idx;
    logic [31:0] val;
    logic [10:0] lo;
    logic [10:0] hi;

    rst        = 1'b1;
    req_valid  = 1'b0;
    mode       = MODE_SET;
    leaf_index = '0;
    leaf_value = '0;
    range_lo   = '0;
    range_hi   = '0;
    for (k = 1; k < 2*LEAVES; k++) min_tree[k] = ALL_ONES;

    // Stimulus table: fixed results are the obvious ones
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd0,    11'd1024, 1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd0,    11'd2047, 1, ALL_ONES);
    add_row(MODE_SET,    10'd0,    32'd0,        11'd0,    11'd0,    0, '0);
    add_row(MODE_SET,    10'd1023, ALL_ONES,     11'd2047, 11'd2047, 0, '0);
    add_row(MODE_SET,    10'd512,  32'd5,        11'd0,    11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd0,    11'd1,    1, 32'd0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd1023, 11'd1024, 1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd1,    11'd1024, 1, 32'd5);
    add_row(MODE_LOWER,  10'd512,  32'd9,        11'd0,    11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd512,  11'd513,  0, '0);
    add_row(MODE_LOWER,  10'd512,  32'd3,        11'd0,    11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd500,  11'd600,  0, '0);
    add_row(MODE_UNUSED, 10'd7,    32'd0,        11'd0,    11'd1024, 0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd7,    11'd8,    1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd300,  11'd300,  1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd900,  11'd100,  1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd1024, 11'd2047, 1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd2047, 11'd2047, 1, ALL_ONES);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd0,    11'd2047, 0, '0);
    add_row(MODE_SET,    10'd0,    ALL_ONES,     11'd0,    11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd0,    11'd1024, 0, '0);
    add_row(MODE_SET,    10'd1023, 32'd0,        11'd0,    11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd1023, 11'd1500, 1, 32'd0);
    add_row(MODE_SET,    10'd511,  32'h8000_0000, 11'd0,   11'd0,    0, '0);
    add_row(MODE_QUERY,  10'd0,    32'd0,        11'd511,  11'd513,  0, '0);

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    rsp_stall_pct = 14;
    foreach (stim_table[i]) begin
      issue_request(stim_table[i].op, stim_table[i].idx, stim_table[i].val,
                    stim_table[i].lo, stim_table[i].hi, stim_table[i].fixed,
                    stim_table[i].want);
    end

    // Random run in four idling phases
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      case (k * 4 / RANDOM_ITEMS)
        0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; rsp_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rsp_stall_pct = 52; end
        default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
      endcase

      pick = $urandom_range(0, 99);
      if (pick < 40)      op = MODE_SET;
      else if (pick < 55) op = MODE_LOWER;
      else if (pick < 95) op = MODE_QUERY;
      else                op = MODE_UNUSED;

      // a narrow window of leaves gets repeated writes and queries
      if ($urandom_range(0, 3) == 0) idx = 10'($urandom_range(0, 15));
      else                           idx = 10'($urandom_range(0, LEAVES - 1));

      case ($urandom_range(0, 5))
        0, 1, 2: val = $urandom;
        3:       val = 32'($urandom_range(0, 255));
        4:       val = '0;
        default: val = ALL_ONES;
      endcase

      case ($urandom_range(0, 9))
        6: begin
          a = $urandom_range(0, 15);
          b = a + $urandom_range(1, 8);
        end
        7: begin
          a = $urandom_range(0, 1100);
          b = $urandom_range(1025, 2047);
        end
        8: begin
          a = $urandom_range(0, 2047);
          b = $urandom_range(0, 2047);
        end
        9: begin
          a = $urandom_range(1, 1024);
          b = $urandom_range(0, a);
        end
        default: begin
          a = $urandom_range(0, 1024);
          b = $urandom_range(0, 1024);
          if (a > b) begin
            pick = a;
            a = b;
            b = pick;
          end
        end
      endcase
      lo = 11'(a);
      hi = 11'(b);

      issue_request(op, idx, val, lo, hi, 1'b0, '0);
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // Drain outstanding results, then allow for a late stray one
    while (pending_min_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: range_minimum_segment_tree.f
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_front.sv
hw/rtl/rmst_back.sv
hw/rtl/range_minimum_segment_tree.sv
tb/tb_range_minimum_segment_tree.sv
